/* hw/rtl/dht_pkg.sv */
`timescale 1ns / 1ps

package dht_pkg;

    localparam int PRIME_W    = 6;
    localparam int SLOT_OUT_W = 5;
    localparam int STATUS_W   = 2;
    localparam int PROBES_W   = 6;
    localparam int DIGIT_BITS = 4;

    localparam logic [PRIME_W-1:0] HASH_PRIME_RESET = 6'd31;
    localparam logic [PRIME_W-1:0] MIN_PRIME        = 6'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_ZERO   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_RED,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CHECK
    } back_state_t;

endpackage

/* hw/rtl/dht_front.sv */
`timescale 1ns / 1ps

module dht_front #(
    parameter int TABLE_SIZE = 32,
    parameter int KEY_BITS   = 16,
    parameter int SLOT_W     = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [dht_pkg::PRIME_W-1:0]  hash_prime,
    input  logic                         hold,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [2*SLOT_W:0]            q_data
);
    import dht_pkg::*;

    localparam int NSTEP   = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W   = NSTEP * DIGIT_BITS;
    localparam int CNT_W   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int TS_CLIP = (TABLE_SIZE > 64) ? 64 : TABLE_SIZE;
    localparam logic [PRIME_W:0] TS_CMP = TS_CLIP[PRIME_W:0];
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEP - 1);

    front_state_t        state_reg, state_next;
    logic [PAD_W-1:0]    key_sh_reg;
    logic [PRIME_W-1:0]  prime_reg;
    logic [PRIME_W-1:0]  rem_reg;
    logic [PRIME_W-1:0]  home_reg;
    logic [PRIME_W-1:0]  step_reg;
    logic                zero_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                accept;
    logic [PRIME_W-1:0]  rem_div;
    logic                home_ge;
    logic                step_ge;
    logic                red_done;

    assign accept = s_valid && s_ready;

    // Restoring remainder, one digit of the key per cycle.
    always_comb begin
        logic [PRIME_W:0] r;
        r = {1'b0, rem_reg};
        for (int d = 0; d < DIGIT_BITS; d++) begin
            r = {r[PRIME_W-1:0], key_sh_reg[PAD_W-1-d]};
            if (r >= {1'b0, prime_reg}) begin
                r = r - {1'b0, prime_reg};
            end
        end
        rem_div = r[PRIME_W-1:0];
    end

    assign home_ge  = {1'b0, home_reg} >= TS_CMP;
    assign step_ge  = {1'b0, step_reg} >= TS_CMP;
    assign red_done = !home_ge && !step_ge;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = (s_key == '0) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = F_RED;
                end
            end
            F_RED: begin
                if (red_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        q_valid = 1'b0;
        case (state_reg)
            F_IDLE:  s_ready = !hold;
            F_PUSH:  q_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                q_valid = 1'b0;
            end
        endcase
    end

    assign q_data = {zero_reg, SLOT_W'(home_reg), SLOT_W'(step_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    key_sh_reg <= PAD_W'(s_key);
                    prime_reg  <= (hash_prime < MIN_PRIME) ? MIN_PRIME : hash_prime;
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    zero_reg   <= (s_key == '0);
                end
            end
            F_DIV: begin
                rem_reg    <= rem_div;
                key_sh_reg <= key_sh_reg << DIGIT_BITS;
                cnt_reg    <= cnt_reg + 1'b1;
                home_reg   <= rem_div;
                step_reg   <= prime_reg - rem_div;
            end
            F_RED: begin
                if (home_ge) begin
                    home_reg <= home_reg - TS_CMP[PRIME_W-1:0];
                end
                if (step_ge) begin
                    step_reg <= step_reg - TS_CMP[PRIME_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/dht_queue.sv */
`timescale 1ns / 1ps

module dht_queue #(
    parameter int WIDTH = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic [1:0]       count_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hw/rtl/dht_back.sv */
`timescale 1ns / 1ps

module dht_back #(
    parameter int TABLE_SIZE = 32,
    parameter int SLOT_W     = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [2*SLOT_W:0]              q_data,
    output logic                           clearing,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dht_pkg::SLOT_OUT_W-1:0] m_slot,
    output logic [dht_pkg::STATUS_W-1:0]   m_status,
    output logic [dht_pkg::PROBES_W-1:0]   m_probes
);
    import dht_pkg::*;

    localparam logic [SLOT_W:0]   TS_EXT = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] TS_M1  = SLOT_W'(TABLE_SIZE - 1);

    // One occupancy bit per table slot.
    logic                  occ_mem [TABLE_SIZE];
    logic                  occ_rd_reg;

    back_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]     clr_reg;
    logic [SLOT_W-1:0]     pos_reg;
    logic [SLOT_W-1:0]     step_reg;
    logic [SLOT_W-1:0]     tries_reg;
    logic                  m_valid_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    status_t               status_reg;
    logic [PROBES_W-1:0]   probes_reg;

    logic                  item_zero;
    logic [SLOT_W-1:0]     item_home;
    logic [SLOT_W-1:0]     item_step;
    logic [SLOT_W:0]       pos_sum;
    logic [SLOT_W:0]       pos_adv;
    logic [SLOT_W-1:0]     pos_next;
    logic                  out_free;

    logic                  q_pop;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic                  mem_wdata;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  res_load;
    status_t               res_status;
    logic [SLOT_OUT_W-1:0] res_slot;
    logic [PROBES_W-1:0]   res_probes;
    logic                  advance;

    assign item_zero = q_data[2*SLOT_W];
    assign item_home = q_data[2*SLOT_W-1:SLOT_W];
    assign item_step = q_data[SLOT_W-1:0];

    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_adv  = (pos_sum >= TS_EXT) ? (pos_sum - TS_EXT) : pos_sum;
    assign pos_next = pos_adv[SLOT_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_reg == TS_M1) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid && out_free && !item_zero) begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK: begin
                if (!occ_rd_reg || (tries_reg == TS_M1)) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = 1'b1;
        rd_addr    = pos_next;
        res_load   = 1'b0;
        res_status = ST_STORED;
        res_slot   = '0;
        res_probes = '0;
        advance    = 1'b0;
        clearing   = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
            end
            B_IDLE: begin
                q_pop   = q_valid && out_free;
                rd_addr = item_home;
                if (q_pop && item_zero) begin
                    res_load   = 1'b1;
                    res_status = ST_ZERO;
                end
            end
            B_CHECK: begin
                if (!occ_rd_reg) begin
                    mem_we     = 1'b1;
                    res_load   = 1'b1;
                    res_status = ST_STORED;
                    res_slot   = SLOT_OUT_W'(pos_reg);
                    res_probes = PROBES_W'(tries_reg);
                end else if (tries_reg == TS_M1) begin
                    res_load   = 1'b1;
                    res_status = ST_FULL;
                    res_probes = PROBES_W'(TABLE_SIZE);
                end else begin
                    advance = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign q_ready  = q_pop;
    assign m_valid  = m_valid_reg;
    assign m_slot   = slot_reg;
    assign m_status = status_reg;
    assign m_probes = probes_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        occ_rd_reg <= occ_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pos_reg   <= item_home;
            step_reg  <= item_step;
            tries_reg <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            tries_reg <= tries_reg + 1'b1;
        end
        if (res_load) begin
            slot_reg   <= res_slot;
            status_reg <= res_status;
            probes_reg <= res_probes;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CLEAR) |-> !q_ready)
        else $error("queue popped during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded over an untaken result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CHECK && mem_we) |=> m_valid_reg)
        else $error("stored key produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_valid_reg)
        else $error("result pending during clearing pass");

endmodule

/* hw/rtl/double_hash_table_insert.sv */
`timescale 1ns / 1ps

// Channel  Ports                                      Word
// input    s_valid s_ready s_key                      one key to insert
// result   m_valid m_ready m_slot m_status m_probes   one insert outcome per key
// config   cfg_valid cfg_ready cfg_hash_prime         hash prime register
//
// In the front a key is accepted, divided in the remainder unit one digit of the key at a time,
// has home and step reduced to the table size, and is pushed, waiting while the queue is full.
// A zero key skips the remainder and the reduction.
// The back takes the word from the queue and then examines the slots one after another.
// After reset the occupancy memory is cleared one slot at a time; no key is taken then.
// A two-word queue between front and back and the result register let each side stall alone.

module double_hash_table_insert #(
    parameter int TABLE_SIZE = 32,
    parameter int KEY_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [KEY_BITS-1:0]            s_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dht_pkg::SLOT_OUT_W-1:0] m_slot,
    output logic [dht_pkg::STATUS_W-1:0]   m_status,
    output logic [dht_pkg::PROBES_W-1:0]   m_probes,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dht_pkg::PRIME_W-1:0]    cfg_hash_prime
);
    import dht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int ITEM_W = 2 * SLOT_W + 1;

    logic [PRIME_W-1:0] hash_prime_reg;
    logic               clearing;
    logic               fq_valid;
    logic               fq_ready;
    logic [ITEM_W-1:0]  fq_data;
    logic               qb_valid;
    logic               qb_ready;
    logic [ITEM_W-1:0]  qb_data;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_prime_reg <= HASH_PRIME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hash_prime_reg <= cfg_hash_prime;
        end
    end

    dht_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key      (s_key),
        .hash_prime (hash_prime_reg),
        .hold       (clearing),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    dht_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    dht_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_slot   (m_slot),
        .m_status (m_status),
        .m_probes (m_probes)
    );

endmodule

/* tb/tb_double_hash_table_insert.sv */
`timescale 1ns / 1ps

module tb_double_hash_table_insert;
    import dht_pkg::*;

    localparam int TABLE_SLOTS    = 32;
    localparam int KEY_W          = 16;
    localparam int RANDOM_KEYS    = 1200;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [SLOT_OUT_W-1:0] slot;
        status_t               status;
        logic [PROBES_W-1:0]   probes;
    } insert_outcome_t;

    class insert_scoreboard;
        logic [KEY_W-1:0]   slot_keys[TABLE_SLOTS];
        logic [PRIME_W-1:0] prime;
        insert_outcome_t    outcome_q[$];
        int                 errors;
        int                 stored;

        function new();
            foreach (slot_keys[i]) slot_keys[i] = '0;
            prime  = HASH_PRIME_RESET;
            errors = 0;
            stored = 0;
        endfunction

        function void set_prime(logic [PRIME_W-1:0] value);
            prime = value;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Walks the probe sequence on the local copy of the table and queues the outcome.
        function void note_key(logic [KEY_W-1:0] key);
            insert_outcome_t res;
            int modulus;
            int rem;
            int step;
            int pos;
            int tries;
            res.slot   = '0;
            res.status = ST_ZERO;
            res.probes = '0;
            if (key != '0) begin
                modulus    = (prime < MIN_PRIME) ? int'(MIN_PRIME) : int'(prime);
                rem        = int'(key) % modulus;
                step       = modulus - rem;
                pos        = rem % TABLE_SLOTS;
                res.status = ST_FULL;
                res.probes = PROBES_W'(TABLE_SLOTS);
                for (tries = 0; tries < TABLE_SLOTS; tries++) begin
                    if (slot_keys[pos] == '0) begin
                        slot_keys[pos] = key;
                        stored++;
                        res.slot   = SLOT_OUT_W'(pos);
                        res.status = ST_STORED;
                        res.probes = PROBES_W'(tries);
                        break;
                    end
                    pos = (pos + step) % TABLE_SLOTS;
                end
            end
            outcome_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_outcome(logic [SLOT_OUT_W-1:0] slot, logic [STATUS_W-1:0] status,
                           logic [PROBES_W-1:0] probes);
            insert_outcome_t want;
            if (outcome_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word slot=%0d status=%0d probes=%0d",
                                          slot, status, probes));
                return;
            end
            want = outcome_q.pop_front();
            if (slot !== want.slot)
                report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (probes !== want.probes)
                report_mismatch($sformatf("probes got %0d want %0d", probes, want.probes));
        endtask

        task check_drained();
            if (outcome_q.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived", outcome_q.size()));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [KEY_W-1:0]      s_key;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic [STATUS_W-1:0]   m_status;
    logic [PROBES_W-1:0]   m_probes;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [PRIME_W-1:0]    cfg_hash_prime;

    insert_scoreboard  sb;
    logic [KEY_W-1:0]  sent_keys[$];
    int                burst_left = 0;
    int                random_sent = 0;
    int                idle_cycles = 0;
    logic [15:0]       rx_tick = '0;

    double_hash_table_insert #(
        .TABLE_SIZE(TABLE_SLOTS),
        .KEY_BITS  (KEY_W)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_status      (m_status),
        .m_probes      (m_probes),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_hash_prime(cfg_hash_prime)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [KEY_W-1:0] random_key();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel <= 2)
            return KEY_W'($urandom_range(1, 63));
        if (sel == 3 && sent_keys.size() != 0)
            return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        return KEY_W'($urandom());
    endfunction

    function automatic logic [PRIME_W-1:0] random_prime();
        int primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        if ($urandom_range(0, 3) == 0)
            return PRIME_W'($urandom_range(0, 63));
        return PRIME_W'(primes[$urandom_range(0, 10)]);
    endfunction

    // The sender runs in bursts; a new burst may open with a gap of idle cycles.
    task automatic offer_key(input logic [KEY_W-1:0] key);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        sb.note_key(key);
        sent_keys.push_back(key);
        burst_left--;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_prime(input logic [PRIME_W-1:0] value);
        cfg_hash_prime <= value;
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_prime(value);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_outcome(m_slot, m_status, m_probes);
        rx_tick <= rx_tick + 1'b1;
        case (rx_tick[9:8])
            2'd0: begin
                m_ready <= 1'b1;
            end
            2'd1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_ready <= (rx_tick[2:0] < 3'd3);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0]   directed_keys[$];
        logic [PRIME_W-1:0] forced_primes[$];
        logic [PRIME_W-1:0] prime_now;
        int                 phase_len;
        int                 n;
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_key          = '0;
        cfg_valid      = 1'b0;
        cfg_hash_prime = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset modulus: zero key, widest keys, shared home slots and a duplicate.
        directed_keys = '{16'h0000, 16'hFFFF, 16'h0001, 16'h001F, 16'h003E,
                          16'h0001, 16'h8000, 16'h5555, 16'hAAAA};
        foreach (directed_keys[i]) offer_key(directed_keys[i]);
        settle();

        // Modulus 2 with even keys walks only even slots, so it gives up with odd slots free.
        write_prime(PRIME_W'(2));
        for (n = 1; n <= 16; n++) offer_key(KEY_W'(n * 2));
        settle();

        forced_primes = '{6'd63, 6'd0, 6'd32, 6'd1, 6'd33};
        while (random_sent < RANDOM_KEYS) begin
            if (forced_primes.size() != 0)
                prime_now = forced_primes.pop_front();
            else
                prime_now = random_prime();
            write_prime(prime_now);
            // Short phases while the table has room, so many moduli see a partly filled table.
            if (sb.stored < TABLE_SLOTS)
                phase_len = $urandom_range(2, 8);
            else
                phase_len = $urandom_range(50, 200);
            for (n = 0; n < phase_len && random_sent < RANDOM_KEYS; n++) begin
                offer_key(random_key());
                random_sent++;
            end
            settle();
        end

        sb.check_drained();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
